@@ rtl/ttd_pkg.sv @@
// Shared types, constants and codes of the tilt-to-differential-drive block.
package ttd_pkg;

    // Field widths.
    localparam int SMP_W  = 16;
    localparam int CFG_W  = 15;
    localparam int SPD_W  = 7;
    localparam int DIR_W  = 2;
    localparam int IDX_W  = 2;

    // Direction codes.
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BWD  = 2'd2;

    // Register indexes.
    localparam logic [IDX_W-1:0] CFG_ACCEL_THR = 2'd0;
    localparam logic [IDX_W-1:0] CFG_GYRO_THR  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MIN_SPEED = 2'd2;
    localparam logic [IDX_W-1:0] CFG_MAX_SPEED = 2'd3;

    // Register reset values.
    localparam logic [CFG_W-1:0] ACCEL_THR_RST = 15'd5000;
    localparam logic [CFG_W-1:0] GYRO_THR_RST  = 15'd3000;
    localparam logic [SPD_W-1:0] MIN_SPEED_RST = 7'd30;
    localparam logic [SPD_W-1:0] MAX_SPEED_RST = 7'd80;

    localparam logic [CFG_W-1:0] FULL_SCALE = 15'd32000;

    // Queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    // Arithmetic widths.
    localparam int SQ_W    = 31;   // square of a 16-bit magnitude
    localparam int SUM_W   = 32;   // sum of two squares
    localparam int ROOT_W  = 16;
    localparam int REM_W   = 19;   // square root partial remainder
    localparam int NUM_W   = 24;   // dividend magnitude, padded
    localparam int DREM_W  = 15;   // division remainder
    localparam int BASE_W  = 26;   // signed base before clamping

    // Pipeline shape of the back end.
    localparam int SQ_STAGES  = 4;
    localparam int SQ_STEPS   = ROOT_W / SQ_STAGES;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = NUM_W / DIV_STAGES;
    localparam int POS_MUL    = SQ_STAGES + 1;
    localparam int POS_BASE   = POS_MUL + DIV_STAGES + 1;
    localparam int NPOS       = POS_BASE + 1;

    // floor(3*b/5) == (b*615) >> 10 for every b below 128.
    localparam int TRIM_MUL   = 615;
    localparam int TRIM_SHIFT = 10;
    localparam int TRIM_W     = SPD_W + TRIM_SHIFT;

    typedef struct packed {
        logic [CFG_W-1:0] acc_lim;
        logic [CFG_W-1:0] rot_lim;
        logic [SPD_W-1:0] min_speed;
        logic [SPD_W-1:0] max_speed;
    } cfg_t;

    typedef struct packed {
        logic acc_mv;
        logic gyr_mv;
        logic ay_mv;
        logic ax_trim;
        logic gz_pos;
        logic ay_pos;
        logic ax_pos;
    } flags_t;

    typedef struct packed {
        logic [SQ_W-1:0] sq_x;
        logic [SQ_W-1:0] sq_y;
        flags_t          flags;
    } cls_t;

endpackage

@@ rtl/ttd_sample_if.sv @@
// Input channel carrying one IMU sample per transaction.
interface ttd_sample_if
    import ttd_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] accel_x;
    logic signed [SMP_W-1:0] accel_y;
    logic signed [SMP_W-1:0] gyro_z;

    modport source (output valid, output accel_x, output accel_y, output gyro_z,
                    input ready);
    modport sink (input valid, input accel_x, input accel_y, input gyro_z,
                  output ready);
endinterface

@@ rtl/ttd_drive_if.sv @@
// Output channel carrying one motor command per transaction.
interface ttd_drive_if
    import ttd_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [DIR_W-1:0] dir_left;
    logic [SPD_W-1:0] speed_left;
    logic [DIR_W-1:0] dir_right;
    logic [SPD_W-1:0] speed_right;
    logic             moving;

    modport source (output valid, output dir_left, output speed_left,
                    output dir_right, output speed_right, output moving,
                    input ready);
    modport sink (input valid, input dir_left, input speed_left,
                  input dir_right, input speed_right, input moving,
                  output ready);
endinterface

@@ rtl/ttd_front.sv @@
// Front end: takes samples, classifies movement and squares the accel magnitudes.
module ttd_front
    import ttd_pkg::*;
(
    ttd_sample_if.sink sample,
    input  cfg_t       cfg,
    input  logic       full,
    output logic       push,
    output cls_t       push_data
);

    logic [SMP_W-1:0] ax_mag;
    logic [SMP_W-1:0] ay_mag;
    logic [SMP_W-1:0] gz_mag;
    logic [SUM_W-1:0] px;
    logic [SUM_W-1:0] py;

    assign sample.ready = !full;
    assign push         = sample.valid && !full;

    // The most negative sample yields 32768, which still fits unsigned.
    assign ax_mag = sample.accel_x[SMP_W-1] ? (~$unsigned(sample.accel_x) + 16'd1)
                                            : $unsigned(sample.accel_x);
    assign ay_mag = sample.accel_y[SMP_W-1] ? (~$unsigned(sample.accel_y) + 16'd1)
                                            : $unsigned(sample.accel_y);
    assign gz_mag = sample.gyro_z[SMP_W-1] ? (~$unsigned(sample.gyro_z) + 16'd1)
                                           : $unsigned(sample.gyro_z);

    assign px = {16'd0, ax_mag} * {16'd0, ax_mag};
    assign py = {16'd0, ay_mag} * {16'd0, ay_mag};

    always_comb
    begin
        push_data.sq_x          = px[SQ_W-1:0];
        push_data.sq_y          = py[SQ_W-1:0];
        push_data.flags.ay_mv   = ay_mag > {1'b0, cfg.acc_lim};
        push_data.flags.acc_mv  = (ax_mag > {1'b0, cfg.acc_lim})
                                  || push_data.flags.ay_mv;
        push_data.flags.gyr_mv  = gz_mag > {1'b0, cfg.rot_lim};
        push_data.flags.ax_trim = ax_mag > {2'b00, cfg.acc_lim[CFG_W-1:1]};
        push_data.flags.gz_pos  = !sample.gyro_z[SMP_W-1] && (sample.gyro_z != '0);
        push_data.flags.ay_pos  = !sample.accel_y[SMP_W-1] && (sample.accel_y != '0);
        push_data.flags.ax_pos  = !sample.accel_x[SMP_W-1] && (sample.accel_x != '0);
    end

endmodule

@@ rtl/ttd_fifo.sv @@
// Short queue of classified samples between the front and back ends.
module ttd_fifo
    import ttd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    input  logic pop,
    output cls_t pop_data,
    output logic full,
    output logic empty
);

    cls_t           mem [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW-1:0] rd_ptr_next;
    logic [QPW:0]   count_reg;
    logic [QPW:0]   count_next;

    assign full     = count_reg == (QPW+1)'(QDEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full)) else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty)) else $error("queue read while empty");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone write");

endmodule

@@ rtl/ttd_back.sv @@
// Back end: square root, scaling divide, clamp and motor command output.
module ttd_back
    import ttd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        empty,
    input  cls_t        pop_data,
    output logic        pop,
    ttd_drive_if.source drive
);

    typedef struct packed {
        logic [SUM_W-1:0]  x;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [NUM_W-1:0]  n;
        logic [DREM_W-1:0] rem;
        logic [NUM_W-1:0]  q;
        logic              neg;
    } div_t;

    function automatic sqrt_t sqrt_steps(input sqrt_t s);
        sqrt_t            r;
        logic [REM_W-1:0] rn;
        logic [REM_W-1:0] trial;
        begin
            r = s;
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                rn    = {r.rem[REM_W-3:0], r.x[SUM_W-1 -: 2]};
                trial = {1'b0, r.root, 2'b01};
                r.x   = r.x << 2;
                if (rn >= trial)
                begin
                    r.rem  = rn - trial;
                    r.root = {r.root[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    r.rem  = rn;
                    r.root = {r.root[ROOT_W-2:0], 1'b0};
                end
            end
            return r;
        end
    endfunction

    function automatic div_t div_steps(input div_t s, input logic [DREM_W-1:0] d);
        div_t              r;
        logic [DREM_W:0]   rem2;
        begin
            r = s;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                rem2 = {r.rem, r.n[NUM_W-1]};
                r.n  = r.n << 1;
                if (rem2 >= {1'b0, d})
                begin
                    r.rem = DREM_W'(rem2 - {1'b0, d});
                    r.q   = {r.q[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    r.rem = rem2[DREM_W-1:0];
                    r.q   = {r.q[NUM_W-2:0], 1'b0};
                end
            end
            return r;
        end
    endfunction

    logic                adv;
    logic [NPOS-1:0]     v_reg;
    flags_t              fl_reg [NPOS];
    logic [SUM_W-1:0]    sum_reg;
    sqrt_t               sq_reg [SQ_STAGES];
    logic [NUM_W-1:0]    mag_reg;
    logic                neg_reg;
    div_t                dv_reg [DIV_STAGES];
    logic [SPD_W-1:0]    base_reg;

    logic                out_valid_reg;
    logic [DIR_W-1:0]    dir_left_reg;
    logic [SPD_W-1:0]    speed_left_reg;
    logic [DIR_W-1:0]    dir_right_reg;
    logic [SPD_W-1:0]    speed_right_reg;
    logic                moving_reg;

    // Scaling terms.
    logic [ROOT_W-1:0]   root;
    logic                m_ge;
    logic [ROOT_W-1:0]   dmag;
    logic                span_neg;
    logic [SPD_W-1:0]    smag;
    logic [NUM_W-1:0]    prod;
    logic [DREM_W-1:0]   dsr;

    // Base speed terms.
    div_t                dv_last;
    logic signed [BASE_W-1:0] s_min;
    logic signed [BASE_W-1:0] s_q;
    logic signed [BASE_W-1:0] val;
    logic [SPD_W-1:0]    base_next;

    // Output terms.
    flags_t              fo;
    logic [TRIM_W-1:0]   trim_prod;
    logic [SPD_W-1:0]    trimmed;
    logic [DIR_W-1:0]    dir_left_next;
    logic [SPD_W-1:0]    speed_left_next;
    logic [DIR_W-1:0]    dir_right_next;
    logic [SPD_W-1:0]    speed_right_next;

    // The whole back pipeline moves together; it holds only while a result waits.
    assign adv = !out_valid_reg || drive.ready;
    assign pop = adv && !empty;

    assign root     = sq_reg[SQ_STAGES-1].root;
    assign m_ge     = root >= {1'b0, cfg.acc_lim};
    assign dmag     = m_ge ? root - {1'b0, cfg.acc_lim}
                           : {1'b0, cfg.acc_lim} - root;
    assign span_neg = cfg.max_speed < cfg.min_speed;
    assign smag     = span_neg ? cfg.min_speed - cfg.max_speed
                               : cfg.max_speed - cfg.min_speed;
    assign prod     = {8'd0, dmag} * {{(NUM_W-SPD_W){1'b0}}, smag};
    // A threshold at or beyond full scale leaves a divisor of one.
    assign dsr      = (cfg.acc_lim >= FULL_SCALE) ? DREM_W'(1)
                                                  : FULL_SCALE - cfg.acc_lim;

    assign dv_last = dv_reg[DIV_STAGES-1];
    assign s_min   = $signed({{(BASE_W-SPD_W){1'b0}}, cfg.min_speed});
    assign s_q     = $signed({{(BASE_W-NUM_W){1'b0}}, dv_last.q});

    always_comb
    begin
        if (fl_reg[POS_BASE-1].acc_mv)
        begin
            val = dv_last.neg ? s_min - s_q : s_min + s_q;
        end
        else
        begin
            val = s_min;
        end
        priority if (val < 0)
        begin
            base_next = '0;
        end
        else if (val > $signed({{(BASE_W-SPD_W){1'b0}}, cfg.max_speed}))
        begin
            base_next = cfg.max_speed;
        end
        else
        begin
            base_next = val[SPD_W-1:0];
        end
    end

    assign fo        = fl_reg[POS_BASE];
    assign trim_prod = {{TRIM_SHIFT{1'b0}}, base_reg} * TRIM_W'(TRIM_MUL);
    assign trimmed   = trim_prod[TRIM_SHIFT +: SPD_W];

    always_comb
    begin
        dir_left_next    = DIR_STOP;
        dir_right_next   = DIR_STOP;
        speed_left_next  = '0;
        speed_right_next = '0;
        priority if (fo.gyr_mv)
        begin
            dir_left_next    = fo.gz_pos ? DIR_FWD : DIR_BWD;
            dir_right_next   = fo.gz_pos ? DIR_BWD : DIR_FWD;
            speed_left_next  = base_reg;
            speed_right_next = base_reg;
        end
        else if (fo.ay_mv)
        begin
            dir_left_next    = fo.ay_pos ? DIR_FWD : DIR_BWD;
            dir_right_next   = dir_left_next;
            speed_left_next  = base_reg;
            speed_right_next = base_reg;
            if (fo.ax_trim)
            begin
                if (fo.ax_pos)
                begin
                    speed_right_next = trimmed;
                end
                else
                begin
                    speed_left_next = trimmed;
                end
            end
        end
        else
        begin
            dir_left_next = DIR_STOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[NPOS-2:0], pop};
            out_valid_reg <= v_reg[NPOS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fl_reg[0] <= pop_data.flags;
            for (int i = 1; i < NPOS; i++)
            begin
                fl_reg[i] <= fl_reg[i-1];
            end
            sum_reg   <= {1'b0, pop_data.sq_x} + {1'b0, pop_data.sq_y};
            sq_reg[0] <= sqrt_steps('{x: sum_reg, rem: '0, root: '0});
            for (int i = 1; i < SQ_STAGES; i++)
            begin
                sq_reg[i] <= sqrt_steps(sq_reg[i-1]);
            end
            mag_reg   <= prod;
            neg_reg   <= !m_ge ^ span_neg;
            dv_reg[0] <= div_steps('{n: mag_reg, rem: '0, q: '0, neg: neg_reg}, dsr);
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                dv_reg[i] <= div_steps(dv_reg[i-1], dsr);
            end
            base_reg        <= base_next;
            dir_left_reg    <= dir_left_next;
            speed_left_reg  <= speed_left_next;
            dir_right_reg   <= dir_right_next;
            speed_right_reg <= speed_right_next;
            moving_reg      <= fo.acc_mv || fo.gyr_mv;
        end
    end

    assign drive.valid       = out_valid_reg;
    assign drive.dir_left    = dir_left_reg;
    assign drive.speed_left  = speed_left_reg;
    assign drive.dir_right   = dir_right_reg;
    assign drive.speed_right = speed_right_reg;
    assign drive.moving      = moving_reg;

    a_stop_left_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (drive.valid && drive.dir_left == DIR_STOP) |-> (drive.speed_left == '0))
        else $error("left motor stopped with a nonzero speed");

    a_still_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (drive.valid && !drive.moving) |->
        (drive.dir_left == DIR_STOP && drive.dir_right == DIR_STOP))
        else $error("motor driven without movement");

    a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && adv) |=> v_reg[0])
        else $error("popped sample did not enter the pipeline");

endmodule

@@ rtl/tilt_to_differential_drive.sv @@
// Top level of the tilt-to-differential-drive block.
//
// The sample channel takes one IMU sample (accel_x, accel_y, gyro_z) per
// transaction; the drive channel returns one motor command (direction and
// speed for left and right, plus the moving flag) per sample, in order.
// Both channels transfer on a clock edge with valid and ready high.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write only while the block is idle (the block itself does not enforce this),
// and writes take effect on the next sample. A sample is classified and squared
// on acceptance and queued; the back end then runs a four-stage square root, a
// scaling multiply, a four-stage divide and the clamp. With the receiver ready,
// one sample is taken every cycle.
// When the receiver stalls, the result register and the back pipeline hold,
// the four-entry queue fills, and sample ready drops once it is full.
// Reset empties the queue and pipeline, drops drive valid and loads the
// register defaults (thresholds 5000 and 3000, speeds 30 and 80).
module tilt_to_differential_drive
    import ttd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    ttd_sample_if.sink       sample,
    ttd_drive_if.source      drive,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    logic push;
    cls_t push_data;
    logic pop;
    cls_t pop_data;
    logic full;
    logic empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.acc_lim   <= ACCEL_THR_RST;
            cfg_reg.rot_lim   <= GYRO_THR_RST;
            cfg_reg.min_speed <= MIN_SPEED_RST;
            cfg_reg.max_speed <= MAX_SPEED_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACCEL_THR: cfg_reg.acc_lim   <= cfg_data;
                CFG_GYRO_THR:  cfg_reg.rot_lim   <= cfg_data;
                CFG_MIN_SPEED: cfg_reg.min_speed <= cfg_data[SPD_W-1:0];
                CFG_MAX_SPEED: cfg_reg.max_speed <= cfg_data[SPD_W-1:0];
            endcase
        end
    end

    ttd_front u_front (
        .sample    (sample),
        .cfg       (cfg_reg),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    ttd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    ttd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .drive    (drive)
    );

endmodule
